### hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on the rising clock, idle in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/lss_pkg.sv
`default_nettype none

package lss_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 8;

  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int ELAPSED_W   = 16;
  localparam int SHOTS_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SPINUP_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOT_TICKS   = 1'd1;

  localparam logic [CFG_W-1:0] SPINUP_TICKS_RST = 16'd5000;
  localparam logic [CFG_W-1:0] SHOT_TICKS_RST   = 16'd250;

  localparam logic [1:0] GOAL_OFF      = 2'd0;
  localparam logic [1:0] GOAL_REV      = 2'd1;
  localparam logic [1:0] GOAL_SHOOT    = 2'd2;
  localparam logic [1:0] GOAL_SHOOT_N  = 2'd3;

  typedef enum logic [1:0] {
    CMD_OFF   = 2'd0,
    CMD_REV   = 2'd1,
    CMD_SHOOT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    SPIN_OFF     = 2'd0,
    SPIN_REVVING = 2'd1,
    SPIN_REVVED  = 2'd2
  } spin_t;

  // per-tick control/status result of the step logic
  typedef struct packed {
    cmd_t  cmd;
    spin_t spin;
    logic  ready;
  } lss_ctl_t;

endpackage

`default_nettype wire

### hdl/launcher_spinup_sequencer_core.sv
`default_nettype none
// Launcher spin-up sequencer, one transaction per control tick.
// Input channel (in_*): enable flag, elapsed ticks, goal mode and wanted shot
// count. Result channel (out_*): drive command, spin status after the tick,
// shot count of the current burst and goal readiness. Both channels use
// valid/stall; a transaction moves on a clock edge with valid high and stall low.
// Config port (cfg_*): write cfg_wdata to register cfg_index when cfg_we is
// high: index 0 spin-up ticks, index 1 shot interval ticks. Write only while idle.
// Path: a transaction accepted into the input register passes through the step
// logic into the output register, which drives the out_* ports. Throughput: one
// transaction per cycle while out_stall is low, set by the combinational state
// update between the input register and the output register.
// Stall: while out_stall holds a result, one more transaction is held in the
// input register; after that in_stall rises until the result is taken.
// Reset (rst_n low, synchronous): spin state off, counter and timers zero,
// registers back to 5000 and 250 ticks, both pipeline stages empty.
module launcher_spinup_sequencer_core #(
  parameter int TIMER_BITS = lss_pkg::TIMER_BITS_DEF,
  parameter int COUNT_BITS = lss_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [lss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lss_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_enabled,
  input  wire logic [lss_pkg::ELAPSED_W-1:0]   in_elapsed_ticks,
  input  wire logic [1:0]                      in_goal_mode,
  input  wire logic [lss_pkg::SHOTS_W-1:0]     in_shots_wanted,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           out_command,
  output logic [1:0]                           out_spin_status,
  output logic [lss_pkg::SHOTS_W-1:0]          out_shots_count,
  output logic                                 out_goal_ready
);
  import lss_pkg::*;

  `include "assert_macros.svh"

  logic [CFG_W-1:0]      spinup_ticks_r;
  logic [CFG_W-1:0]      shot_ticks_r;

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  logic                  s1_enabled_r;
  logic [ELAPSED_W-1:0]  s1_elapsed_r;
  logic [1:0]            s1_goal_r;
  logic [SHOTS_W-1:0]    s1_wanted_r;
  logic                  s1_adv;
  logic                  in_accept;

  spin_t                 spin_r;
  cmd_t                  prev_cmd_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [TIMER_BITS-1:0] spinup_left_r;
  logic [TIMER_BITS-1:0] interval_left_r;

  logic [COUNT_BITS-1:0] cnt_nxt;
  logic [TIMER_BITS-1:0] spinup_left_nxt;
  logic [TIMER_BITS-1:0] interval_left_nxt;
  lss_ctl_t              ctl;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [1:0]            out_command_r;
  logic [1:0]            out_spin_r;
  logic [SHOTS_W-1:0]    out_shots_r;
  logic                  out_ready_r;

  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spinup_ticks_r <= SPINUP_TICKS_RST;
      shot_ticks_r   <= SHOT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPINUP_TICKS: spinup_ticks_r <= cfg_wdata;
        CFG_SHOT_TICKS:   shot_ticks_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_enabled_r <= in_enabled;
      s1_elapsed_r <= in_elapsed_ticks;
      s1_goal_r    <= in_goal_mode;
      s1_wanted_r  <= in_shots_wanted;
    end
  end

  lss_step #(
    .TIMER_BITS (TIMER_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .spin_cur          (spin_r),
    .prev_cmd          (prev_cmd_r),
    .cnt_cur           (cnt_r),
    .spinup_left_cur   (spinup_left_r),
    .interval_left_cur (interval_left_r),
    .spinup_ticks      (spinup_ticks_r),
    .shot_ticks        (shot_ticks_r),
    .enabled           (s1_enabled_r),
    .elapsed_ticks     (s1_elapsed_r),
    .goal_mode         (s1_goal_r),
    .shots_wanted      (s1_wanted_r),
    .cnt_nxt           (cnt_nxt),
    .spinup_left_nxt   (spinup_left_nxt),
    .interval_left_nxt (interval_left_nxt),
    .ctl               (ctl)
  );

  // sequencer state moves once per transaction, when it enters the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_r          <= SPIN_OFF;
      prev_cmd_r      <= CMD_OFF;
      cnt_r           <= '0;
      spinup_left_r   <= '0;
      interval_left_r <= '0;
    end else if (s1_valid_r && s1_adv) begin
      spin_r          <= ctl.spin;
      prev_cmd_r      <= ctl.cmd;
      cnt_r           <= cnt_nxt;
      spinup_left_r   <= spinup_left_nxt;
      interval_left_r <= interval_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_command_r <= ctl.cmd;
      out_spin_r    <= ctl.spin;
      out_shots_r   <= SHOTS_W'(cnt_nxt);
      out_ready_r   <= ctl.ready;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_command     = out_command_r;
  assign out_spin_status = out_spin_r;
  assign out_shots_count = out_shots_r;
  assign out_goal_ready  = out_ready_r;

  `ASSERT_NEXT(a_stage_moves, clk, rst_n, s1_valid_r && s1_adv, out_valid_r)
  `ASSERT_IMPLIES(a_shoot_revved, clk, rst_n, out_valid_r && (out_command_r == CMD_SHOOT),
                  out_spin_r == SPIN_REVVED)
  `ASSERT_IMPLIES(a_count_only_revved, clk, rst_n, spin_r != SPIN_REVVED, cnt_r == '0)

endmodule

`default_nettype wire

### hdl/lss_step.sv
`default_nettype none

module lss_step #(
  parameter int TIMER_BITS = lss_pkg::TIMER_BITS_DEF,
  parameter int COUNT_BITS = lss_pkg::COUNT_BITS_DEF
) (
  input  wire lss_pkg::spin_t             spin_cur,
  input  wire lss_pkg::cmd_t              prev_cmd,
  input  wire logic [COUNT_BITS-1:0]      cnt_cur,
  input  wire logic [TIMER_BITS-1:0]      spinup_left_cur,
  input  wire logic [TIMER_BITS-1:0]      interval_left_cur,
  input  wire logic [lss_pkg::CFG_W-1:0]  spinup_ticks,
  input  wire logic [lss_pkg::CFG_W-1:0]  shot_ticks,
  input  wire logic                       enabled,
  input  wire logic [lss_pkg::ELAPSED_W-1:0] elapsed_ticks,
  input  wire logic [1:0]                 goal_mode,
  input  wire logic [lss_pkg::SHOTS_W-1:0] shots_wanted,
  output logic [COUNT_BITS-1:0]           cnt_nxt,
  output logic [TIMER_BITS-1:0]           spinup_left_nxt,
  output logic [TIMER_BITS-1:0]           interval_left_nxt,
  output lss_pkg::lss_ctl_t               ctl
);
  import lss_pkg::*;

  localparam int TW = (TIMER_BITS > ELAPSED_W) ? TIMER_BITS : ELAPSED_W;
  localparam int CW = (COUNT_BITS > SHOTS_W) ? COUNT_BITS : SHOTS_W;

  logic [TW-1:0]         el_x;
  logic [TW-1:0]         sp_x;
  logic [TW-1:0]         iv_x;
  logic [TIMER_BITS-1:0] sp_run;
  logic [TIMER_BITS-1:0] iv_run;
  logic [TIMER_BITS-1:0] sp_load;
  logic [TIMER_BITS-1:0] iv_load;
  logic                  cnt_ge;
  logic                  revved;
  cmd_t                  cmd;
  spin_t                 spin_nxt;
  logic [COUNT_BITS-1:0] cnt_tmp;
  logic [TIMER_BITS-1:0] iv_tmp;

  assign el_x    = TW'(elapsed_ticks);
  assign sp_x    = TW'(spinup_left_cur);
  assign iv_x    = TW'(interval_left_cur);
  assign sp_load = TIMER_BITS'(spinup_ticks);
  assign iv_load = TIMER_BITS'(shot_ticks);
  assign cnt_ge  = CW'(cnt_cur) >= CW'(shots_wanted);
  assign revved  = (spin_cur == SPIN_REVVED);

  // countdown timers freeze while disabled and stop at zero
  always_comb begin
    sp_run = spinup_left_cur;
    iv_run = interval_left_cur;
    if (enabled) begin
      sp_run = (el_x >= sp_x) ? '0 : TIMER_BITS'(sp_x - el_x);
      iv_run = (el_x >= iv_x) ? '0 : TIMER_BITS'(iv_x - el_x);
    end
  end

  always_comb begin
    unique case (goal_mode)
      GOAL_OFF:     cmd = CMD_OFF;
      GOAL_REV:     cmd = CMD_REV;
      GOAL_SHOOT:   cmd = revved ? CMD_SHOOT : CMD_REV;
      GOAL_SHOOT_N: cmd = cnt_ge ? CMD_REV : (revved ? CMD_SHOOT : CMD_REV);
      default:      cmd = CMD_OFF;
    endcase
  end

  always_comb begin
    spin_nxt          = spin_cur;
    cnt_nxt           = cnt_cur;
    spinup_left_nxt   = sp_run;
    interval_left_nxt = iv_run;
    cnt_tmp           = cnt_cur;
    iv_tmp            = iv_run;
    unique case (spin_cur)
      SPIN_REVVED: begin
        if (cmd == CMD_OFF) begin
          spin_nxt = SPIN_OFF;
          cnt_nxt  = '0;
        end else if (cmd == CMD_SHOOT) begin
          // new burst after rev: restart count and interval
          if (prev_cmd == CMD_REV) begin
            cnt_tmp = '0;
            iv_tmp  = iv_load;
          end
          if (iv_tmp == '0) begin
            if (cnt_tmp != {COUNT_BITS{1'b1}}) begin
              cnt_tmp = cnt_tmp + 1'b1;
            end
            iv_tmp = iv_load;
          end
          cnt_nxt           = cnt_tmp;
          interval_left_nxt = iv_tmp;
        end else if (prev_cmd == CMD_SHOOT) begin
          cnt_nxt = '0;
        end
      end
      SPIN_REVVING: begin
        // off wins over a finished spin-up timer
        if (cmd == CMD_OFF) begin
          spin_nxt = SPIN_OFF;
        end else if (sp_run == '0) begin
          spin_nxt = SPIN_REVVED;
        end
      end
      default: begin
        spin_nxt = SPIN_OFF;
        if (cmd == CMD_REV) begin
          spin_nxt        = SPIN_REVVING;
          spinup_left_nxt = sp_load;
        end
      end
    endcase
  end

  always_comb begin
    ctl.cmd   = cmd;
    ctl.spin  = spin_nxt;
    ctl.ready = (goal_mode == GOAL_OFF) ? (spin_nxt == SPIN_OFF) : (spin_nxt == SPIN_REVVED);
  end

endmodule

`default_nettype wire

### verif/tb_top.sv
`default_nettype none

module tb_top;
  import lss_pkg::*;

  typedef struct {
    cmd_t             cmd;
    spin_t            spin;
    logic [SHOTS_W-1:0] shots;
    logic             ready;
  } tick_status_t;

  // Tracks the sequencer state and holds the status expected for each accepted tick
  class spin_tracker;
    logic [CFG_W-1:0]   spinup_cfg;
    logic [CFG_W-1:0]   shot_cfg;
    logic [CFG_W-1:0]   spinup_rem;
    logic [CFG_W-1:0]   shot_rem;
    spin_t              spin;
    cmd_t               last_cmd;
    logic [SHOTS_W-1:0] burst_count;
    tick_status_t       pending_status[$];
    int                 mismatches;

    function new();
      spinup_cfg  = SPINUP_TICKS_RST;
      shot_cfg    = SHOT_TICKS_RST;
      spinup_rem  = '0;
      shot_rem    = '0;
      spin        = SPIN_OFF;
      last_cmd    = CMD_OFF;
      burst_count = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_SPINUP_TICKS) begin
        spinup_cfg = val;
      end else begin
        shot_cfg = val;
      end
    endfunction

    function void predict_tick(logic en, logic [ELAPSED_W-1:0] elapsed, logic [1:0] goal,
                               logic [SHOTS_W-1:0] wanted);
      cmd_t         cmd;
      tick_status_t res;
      case (goal)
        GOAL_SHOOT_N: begin
          if (burst_count >= wanted) cmd = CMD_REV;
          else cmd = (spin == SPIN_REVVED) ? CMD_SHOOT : CMD_REV;
        end
        GOAL_SHOOT: cmd = (spin == SPIN_REVVED) ? CMD_SHOOT : CMD_REV;
        GOAL_REV:   cmd = CMD_REV;
        default:    cmd = CMD_OFF;
      endcase
      // timers freeze while disabled, otherwise count down and stick at zero
      if (en) begin
        spinup_rem = (elapsed >= spinup_rem) ? '0 : spinup_rem - elapsed;
        shot_rem   = (elapsed >= shot_rem) ? '0 : shot_rem - elapsed;
      end
      case (spin)
        SPIN_REVVED: begin
          if (cmd == CMD_OFF) begin
            spin        = SPIN_OFF;
            burst_count = '0;
          end else if (cmd == CMD_SHOOT) begin
            if (last_cmd == CMD_REV) begin
              burst_count = '0;
              shot_rem    = shot_cfg;
            end
            if (shot_rem == '0) begin
              if (burst_count != '1) burst_count++;
              shot_rem = shot_cfg;
            end
          end else if (last_cmd == CMD_SHOOT) begin
            burst_count = '0;
          end
        end
        SPIN_REVVING: begin
          // off wins even when the spin-up timer has run out
          if (cmd == CMD_OFF) spin = SPIN_OFF;
          else if (spinup_rem == '0) spin = SPIN_REVVED;
        end
        default: begin
          spin = SPIN_OFF;
          if (cmd == CMD_REV) begin
            spin       = SPIN_REVVING;
            spinup_rem = spinup_cfg;
          end
        end
      endcase
      last_cmd  = cmd;
      res.cmd   = cmd;
      res.spin  = spin;
      res.shots = burst_count;
      res.ready = (goal == GOAL_OFF) ? (spin == SPIN_OFF) : (spin == SPIN_REVVED);
      pending_status.push_back(res);
    endfunction

    function void check_status(logic [1:0] cmd, logic [1:0] spin_st,
                               logic [SHOTS_W-1:0] shots, logic ready);
      tick_status_t exp;
      if (pending_status.size() == 0) begin
        $error("result transaction with no tick pending");
        mismatches++;
        return;
      end
      exp = pending_status.pop_front();
      if (exp.cmd !== cmd) begin
        $error("command: expected %0d, got %0d", exp.cmd, cmd);
        mismatches++;
      end
      if (exp.spin !== spin_st) begin
        $error("spin_status: expected %0d, got %0d", exp.spin, spin_st);
        mismatches++;
      end
      if (exp.shots !== shots) begin
        $error("shots_count: expected %0d, got %0d", exp.shots, shots);
        mismatches++;
      end
      if (exp.ready !== ready) begin
        $error("goal_ready: expected %0d, got %0d", exp.ready, ready);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_enabled;
  logic [ELAPSED_W-1:0] in_elapsed_ticks;
  logic [1:0]           in_goal_mode;
  logic [SHOTS_W-1:0]   in_shots_wanted;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_command;
  logic [1:0]           out_spin_status;
  logic [SHOTS_W-1:0]   out_shots_count;
  logic                 out_goal_ready;

  spin_tracker tracker = new();
  bit          no_idle = 1'b0;
  bit          long_hold_done = 1'b0;
  int          results_seen = 0;

  launcher_spinup_sequencer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_enabled       (in_enabled),
    .in_elapsed_ticks (in_elapsed_ticks),
    .in_goal_mode     (in_goal_mode),
    .in_shots_wanted  (in_shots_wanted),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .out_spin_status  (out_spin_status),
    .out_shots_count  (out_shots_count),
    .out_goal_ready   (out_goal_ready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_tick(input logic en, input logic [ELAPSED_W-1:0] elapsed,
                           input logic [1:0] goal, input logic [SHOTS_W-1:0] wanted);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid         <= 1'b0;
      in_enabled       <= 1'($urandom);
      in_elapsed_ticks <= ELAPSED_W'($urandom);
      in_goal_mode     <= 2'($urandom);
      in_shots_wanted  <= SHOTS_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_enabled       <= en;
    in_elapsed_ticks <= elapsed;
    in_goal_mode     <= goal;
    in_shots_wanted  <= wanted;
    do @(posedge clk); while (in_stall);
    tracker.predict_tick(en, elapsed, goal, wanted);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(idx, val);
    @(negedge clk);
  endtask

  // Goals are held for runs of ticks, like a real operator would; some ticks are noise.
  task automatic run_random(input int n, input bit quiet);
    logic [1:0]           goal;
    logic [ELAPSED_W-1:0] elapsed;
    logic [SHOTS_W-1:0]   wanted;
    logic                 en;
    int                   run_left;
    int                   r;
    goal     = GOAL_OFF;
    wanted   = '0;
    run_left = 0;
    no_idle  = quiet;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_idle();
      if (run_left == 0) begin
        run_left = $urandom_range(1, 20);
        r = $urandom_range(0, 99);
        if (r < 15) goal = GOAL_OFF;
        else if (r < 35) goal = GOAL_REV;
        else if (r < 70) goal = GOAL_SHOOT;
        else goal = GOAL_SHOOT_N;
        wanted = ($urandom_range(0, 3) == 0) ? SHOTS_W'($urandom)
                                             : SHOTS_W'($urandom_range(0, 6));
      end
      run_left--;
      en = ($urandom_range(0, 6) != 0);
      case ($urandom_range(0, 3))
        0: elapsed = ELAPSED_W'($urandom_range(0, 15));
        1: elapsed = ELAPSED_W'($urandom_range(0, 300));
        2: elapsed = ELAPSED_W'($urandom);
        default: begin
          case ($urandom_range(0, 3))
            0: elapsed = '0;
            1: elapsed = '1;
            2: elapsed = tracker.spinup_cfg;
            default: elapsed = tracker.shot_cfg;
          endcase
        end
      endcase
      if ($urandom_range(0, 9) == 0) send_tick(en, elapsed, 2'($urandom), SHOTS_W'($urandom));
      else send_tick(en, elapsed, goal, wanted);
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_side
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 13);
      // one long back-pressure stretch so the block fills and stalls its input
      if (!long_hold_done && results_seen >= 60) begin
        hold           = 80;
        long_hold_done = 1'b1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      tracker.check_status(out_command, out_spin_status, out_shots_count, out_goal_ready);
      results_seen++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_enabled       = 1'b0;
    in_elapsed_ticks = '0;
    in_goal_mode     = GOAL_OFF;
    in_shots_wanted  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed ticks at the reset register values
    send_tick(1'b0, 16'd0, GOAL_OFF, 8'd0);
    send_tick(1'b0, 16'hFFFF, GOAL_SHOOT, 8'd0);   // disabled: spin-up timer frozen
    send_tick(1'b0, 16'hFFFF, GOAL_REV, 8'd0);
    send_tick(1'b1, 16'hFFFF, GOAL_OFF, 8'd0);     // off beats a finished timer
    send_tick(1'b1, 16'd0, GOAL_REV, 8'd0);
    send_tick(1'b1, 16'd4999, GOAL_REV, 8'd0);
    send_tick(1'b1, 16'd1, GOAL_SHOOT, 8'd0);
    send_tick(1'b1, 16'd0, GOAL_SHOOT, 8'd0);      // first shoot after rev
    send_tick(1'b1, 16'd250, GOAL_SHOOT, 8'd0);
    send_tick(1'b0, 16'hFFFF, GOAL_SHOOT, 8'd0);
    send_tick(1'b1, 16'd300, GOAL_SHOOT_N, 8'd1);  // quota met: back to rev
    send_tick(1'b1, 16'hFFFF, GOAL_SHOOT_N, 8'hFF);
    send_tick(1'b1, 16'hFFFF, GOAL_SHOOT_N, 8'hFF);
    send_tick(1'b1, 16'd7, GOAL_SHOOT_N, 8'd0);
    send_tick(1'b1, 16'd0, GOAL_OFF, 8'hFF);
    send_tick(1'b1, 16'h5555, GOAL_SHOOT_N, 8'hAA);
    send_tick(1'b1, 16'hAAAA, GOAL_REV, 8'h55);
    send_tick(1'b1, 16'd3, GOAL_OFF, 8'd0);

    wait_idle();
    set_reg(CFG_SPINUP_TICKS, 16'd0);
    set_reg(CFG_SHOT_TICKS, 16'd0);
    run_random(30, 1'b0);

    wait_idle();
    set_reg(CFG_SPINUP_TICKS, 16'hFFFF);
    set_reg(CFG_SHOT_TICKS, 16'hFFFF);
    run_random(25, 1'b0);

    wait_idle();
    set_reg(CFG_SPINUP_TICKS, 16'd20);
    set_reg(CFG_SHOT_TICKS, 16'd5);
    run_random(30, 1'b0);

    wait_idle();
    set_reg(CFG_SPINUP_TICKS, 16'd300);
    set_reg(CFG_SHOT_TICKS, 16'd40);
    run_random(25, 1'b1);

    // long burst with a zero shot interval drives the counter into saturation
    wait_idle();
    set_reg(CFG_SPINUP_TICKS, 16'd3);
    set_reg(CFG_SHOT_TICKS, 16'd0);
    repeat (270) send_tick(1'b1, ELAPSED_W'($urandom_range(0, 4)), GOAL_SHOOT, 8'd0);
    send_tick(1'b1, 16'd1, GOAL_SHOOT_N, 8'hFF);
    send_tick(1'b1, 16'd1, GOAL_SHOOT_N, 8'hFF);
    send_tick(1'b1, 16'd1, GOAL_OFF, 8'd0);

    wait_idle();
    repeat (10) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.pending_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+hdl
hdl/lss_pkg.sv
hdl/lss_step.sv
hdl/launcher_spinup_sequencer_core.sv
verif/tb_top.sv
